// ----- rtl/b64sc_pkg.sv -----
// Shared types, constants and alphabet functions for the Base64 stream codec.
// No dependencies.
package b64sc_pkg;

    localparam int GRP_W      = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_PAD = 8'h3D;    // '='
    localparam logic       DIR_ENC = 1'b0;
    localparam logic       DIR_DEC = 1'b1;

    // One collected group, handed from the front end to the emitter.
    typedef struct packed {
        logic             dir;    // DIR_ENC or DIR_DEC
        logic [GRP_W-1:0] bits;   // group, first item in the high bits
        logic [1:0]       cnt;    // encode: bytes collected (1..3)
        logic             last;   // group closes the stream
    } t_grp;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
        logic [7:0] c;
        c = {2'b00, s};
        if (s < 6'd26) begin
            sextet_to_char = 8'h41 + c;
        end else if (s < 6'd52) begin
            sextet_to_char = 8'h61 + c - 8'd26;
        end else if (s < 6'd62) begin
            sextet_to_char = 8'h30 + c - 8'd52;
        end else if (s == 6'd62) begin
            sextet_to_char = 8'h2B;
        end else begin
            sextet_to_char = 8'h2F;
        end
    endfunction

    // Characters outside the alphabet, '=' included, map to zero.
    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else if (c == 8'h2F) begin
            t = 8'd63;
        end
        char_to_sextet = t[5:0];
    endfunction

endpackage

// ----- rtl/b64sc_front.sv -----
// Front end: holds the direction register, gathers items into groups and
// pushes each finished group. Depends on b64sc_pkg.
module b64sc_front import b64sc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_dir,
    input  logic       i_acc,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_grp       o_grp
);

    logic             r_dir, n_dir;
    logic [GRP_W-1:0] r_bits, n_bits;
    logic [1:0]       r_cnt, n_cnt;

    logic [GRP_W-1:0] merged;
    logic [2:0]       n_items;
    logic [5:0]       sx;

    always_comb begin
        sx      = char_to_sextet(i_byte);
        n_items = {1'b0, r_cnt} + 3'd1;
        if (r_dir == DIR_ENC) begin
            case (r_cnt)
                2'd0:    merged = r_bits | {i_byte, 16'd0};
                2'd1:    merged = r_bits | {8'd0, i_byte, 8'd0};
                default: merged = r_bits | {16'd0, i_byte};
            endcase
        end else begin
            case (r_cnt)
                2'd0:    merged = r_bits | {sx, 18'd0};
                2'd1:    merged = r_bits | {6'd0, sx, 12'd0};
                2'd2:    merged = r_bits | {12'd0, sx, 6'd0};
                default: merged = r_bits | {18'd0, sx};
            endcase
        end

        n_dir  = r_dir;
        n_bits = r_bits;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_grp  = '{dir: r_dir, bits: merged, cnt: n_items[1:0], last: i_last};

        if (i_cfg_we) begin
            n_dir  = i_cfg_dir;
            n_bits = '0;
            n_cnt  = 2'd0;
        end else if (i_acc) begin
            if (r_dir == DIR_ENC) begin
                if (n_items >= 3'd3 || i_last) begin
                    o_push = 1'b1;
                    n_bits = '0;
                    n_cnt  = 2'd0;
                end else begin
                    n_bits = merged;
                    n_cnt  = n_items[1:0];
                end
            end else begin
                if (n_items == 3'd4) begin
                    o_push = 1'b1;
                    n_bits = '0;
                    n_cnt  = 2'd0;
                end else if (i_last) begin
                    // trailing partial group is dropped
                    n_bits = '0;
                    n_cnt  = 2'd0;
                end else begin
                    n_bits = merged;
                    n_cnt  = n_items[1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_ENC;
            r_bits <= '0;
            r_cnt  <= 2'd0;
        end else begin
            r_dir  <= n_dir;
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- rtl/b64sc_fifo.sv -----
// Small group queue between front end and emitter.
// Depends on b64sc_pkg.
module b64sc_fifo import b64sc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_grp i_grp,
    input  logic i_pop,
    output t_grp o_grp,
    output logic o_full,
    output logic o_empty
);

    t_grp               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
        o_empty = (r_cnt == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_grp   = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/b64sc_back.sv -----
// Emitter: takes groups from the queue and, unless output stalls, sends
// one character or byte per cycle via an output register. Uses b64sc_pkg.
module b64sc_back import b64sc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_grp       i_grp,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    t_grp       r_ent;
    logic       r_busy;
    logic [1:0] r_k;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;

    logic       adv, fire, done;
    logic [1:0] last_k;
    logic [5:0] sx;
    logic [7:0] enc_ch, dec_b, ch;
    logic       lst;

    always_comb begin
        adv    = !r_ov || i_ready;
        fire   = r_busy && adv;
        last_k = (r_ent.dir == DIR_DEC) ? 2'd2 : 2'd3;
        done   = fire && (r_k == last_k);
        o_pop  = !i_empty && (!r_busy || done);

        case (r_k)
            2'd0:    sx = r_ent.bits[23:18];
            2'd1:    sx = r_ent.bits[17:12];
            2'd2:    sx = r_ent.bits[11:6];
            default: sx = r_ent.bits[5:0];
        endcase
        case (r_k)
            2'd0:    dec_b = r_ent.bits[23:16];
            2'd1:    dec_b = r_ent.bits[15:8];
            default: dec_b = r_ent.bits[7:0];
        endcase

        enc_ch = sextet_to_char(sx);
        // pad: third char when one byte, fourth when fewer than three
        if ((r_k == 2'd2 && r_ent.cnt < 2'd2) || (r_k == 2'd3 && r_ent.cnt < 2'd3)) begin
            enc_ch = CH_PAD;
        end

        ch  = (r_ent.dir == DIR_DEC) ? dec_b : enc_ch;
        lst = r_ent.last && (r_k == last_k);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_grp;
        end
        if (fire) begin
            r_ob <= ch;
            r_ol <= lst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (fire) begin
                r_k <= r_k + 2'd1;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

endmodule

// ----- rtl/base64_stream_codec_top.sv -----
// Base64 stream codec, top level. Uses b64sc_pkg, b64sc_front, b64sc_fifo,
// b64sc_back.
// A closed group passes the queue, the emitter's group register and its output register.
// Throughput: one output per cycle while the output is not stalled, set by the single
// emitter; decode sustains one input per cycle, encode fewer (three bytes, four chars).
// Reset: synchronous active-low; clears direction (encode), group and queue.
module base64_stream_codec_top import b64sc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config: direction, 0 encode / 1 decode
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // end_of_stream
    // output stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast    // out_last
);

    t_grp front_grp, q_grp;
    logic push, pop, q_full, q_empty, in_acc, cfg_we;

    // Config is always taken; the user must write it only while the codec is idle, which the block leaves unchecked.
    assign o_cfg_ready     = 1'b1;
    assign cfg_we          = i_cfg_valid;
    // Input stalls only when the group queue is full.
    assign o_s_axis_tready = !q_full;
    assign in_acc          = i_s_axis_tvalid && !q_full;

    b64sc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (cfg_we),
        .i_cfg_dir(i_cfg_data),
        .i_acc    (in_acc),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (push),
        .o_grp    (front_grp)
    );

    b64sc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_grp  (front_grp),
        .i_pop  (pop),
        .o_grp  (q_grp),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    b64sc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_grp  (q_grp),
        .i_empty(q_empty),
        .o_pop  (pop),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_byte (o_m_axis_tdata),
        .o_last (o_m_axis_tlast)
    );

endmodule
